[hdl/pru_pkg.sv]
`default_nettype none

package pru_pkg;

   localparam int MAX_ROW_BYTES_DEF   = 4096;
   localparam int MAX_PIXEL_BYTES_DEF = 8;

   localparam int POS_W  = 13;
   localparam int BPP_W  = 4;
   localparam int SLOT_W = 3;
   localparam int BYTE_W = 8;
   localparam int FILT_W = 3;

   localparam logic [BYTE_W-1:0] FILTER_KINDS = 8'd5;

   localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
   localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
   localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
   localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
   localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES       = 1'b1;

   typedef enum logic [1:0] {
      ITEM_NONE,
      ITEM_PIXEL,
      ITEM_BAD
   } item_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              image_start;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              row_end;
      logic              bad_filter;
   } rsp_type;

   typedef struct packed {
      logic [BPP_W-1:0] bytes_per_pixel;
      logic [POS_W-1:0] row_length;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic advance;
   } flow_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [FILT_W-1:0] filter;
      logic [POS_W-1:0]  idx;
      logic [SLOT_W-1:0] slot;
      logic              use_left;
      logic              use_upper;
      logic              last;
      logic [BYTE_W-1:0] data;
   } stage_type;

endpackage

`default_nettype wire

[hdl/pru_prior_mem.sv]
`default_nettype none

module pru_prior_mem #(
   parameter int MAX_ROW_BYTES = pru_pkg::MAX_ROW_BYTES_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] wr_addr,
   input  wire logic [pru_pkg::BYTE_W-1:0]              wr_data,
   input  wire logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] rd_addr,
   output logic      [pru_pkg::BYTE_W-1:0]              rd_data
);

   logic [pru_pkg::BYTE_W-1:0] mem_ff [MAX_ROW_BYTES];
   logic [pru_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/pru_ctrl.sv]
`default_nettype none

module pru_ctrl #(
   parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pru_pkg::flow_type  flow,
   input  wire pru_pkg::cfg_type   cfg,
   input  wire pru_pkg::req_type   req,
   output logic                    s1_valid,
   output pru_pkg::stage_type      s1,
   output logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] rd_addr
);

   localparam int ADDR_W = MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int HIST_W = MAX_PIXEL_BYTES > 1 ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int LEN_W  = 17;

   logic [pru_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [pru_pkg::FILT_W-1:0] filter_ff, filter_in;
   logic                       no_prior_ff, no_prior_in;
   logic                       discard_ff, discard_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic [pru_pkg::SLOT_W-1:0] mod_ff [MAX_PIXEL_BYTES];
   logic [pru_pkg::SLOT_W-1:0] mod_in [MAX_PIXEL_BYTES];
   pru_pkg::stage_type         s1_ff, s1_in;

   logic [pru_pkg::BPP_W-1:0]  eff_bpp;
   logic [LEN_W-1:0]           row_len;
   logic [pru_pkg::POS_W-1:0]  idx;
   logic                       last;

   always_comb begin
      eff_bpp = cfg.bytes_per_pixel;
      if (eff_bpp == '0) begin
         eff_bpp = pru_pkg::BPP_W'(1);
      end else if (32'(eff_bpp) > MAX_PIXEL_BYTES) begin
         eff_bpp = pru_pkg::BPP_W'(MAX_PIXEL_BYTES);
      end
      row_len = LEN_W'(cfg.row_length);
      if (row_len == '0) begin
         row_len = LEN_W'(1);
      end else if (row_len > LEN_W'(MAX_ROW_BYTES)) begin
         row_len = LEN_W'(MAX_ROW_BYTES);
      end
      idx = pos_ff - pru_pkg::POS_W'(1);
      if (LEN_W'(idx) >= LEN_W'(MAX_ROW_BYTES)) begin
         idx = pru_pkg::POS_W'(MAX_ROW_BYTES - 1);
      end
      last = LEN_W'(pos_ff) >= row_len;
   end

   always_comb begin
      pos_in      = pos_ff;
      filter_in   = filter_ff;
      no_prior_in = no_prior_ff;
      discard_in  = discard_ff;
      mod_in      = mod_ff;
      s1_in           = s1_ff;
      s1_in.kind      = pru_pkg::ITEM_NONE;
      s1_in.filter    = filter_ff;
      s1_in.idx       = idx;
      s1_in.slot      = mod_ff[HIST_W'(eff_bpp - pru_pkg::BPP_W'(1))];
      s1_in.use_left  = idx >= pru_pkg::POS_W'(eff_bpp);
      s1_in.use_upper = !no_prior_ff;
      s1_in.last      = last;
      s1_in.data      = req.data_byte;
      if (flow.accept) begin
         if (pos_ff == '0) begin
            pos_in = pru_pkg::POS_W'(1);
            if (req.image_start) begin
               no_prior_in = 1'b1;
            end
            for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
               mod_in[m] = '0;
            end
            if (req.data_byte >= pru_pkg::FILTER_KINDS) begin
               filter_in  = pru_pkg::FILT_NONE;
               discard_in = 1'b1;
               s1_in.kind = pru_pkg::ITEM_BAD;
            end else begin
               filter_in  = req.data_byte[pru_pkg::FILT_W-1:0];
               discard_in = 1'b0;
            end
         end else begin
            pos_in = last ? '0 : pos_ff + pru_pkg::POS_W'(1);
            for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
               mod_in[m] = (mod_ff[m] == pru_pkg::SLOT_W'(m)) ? '0
                                                              : mod_ff[m] + pru_pkg::SLOT_W'(1);
            end
            if (discard_ff) begin
               if (last) begin
                  discard_in = 1'b0;
               end
            end else begin
               s1_in.kind = pru_pkg::ITEM_PIXEL;
               if (last) begin
                  no_prior_in = 1'b0;
               end
            end
         end
      end
      s1_valid_in = flow.advance ? flow.accept : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         filter_ff   <= pru_pkg::FILT_NONE;
         no_prior_ff <= 1'b1;
         discard_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
            mod_ff[m] <= '0;
         end
      end else begin
         pos_ff      <= pos_in;
         filter_ff   <= filter_in;
         no_prior_ff <= no_prior_in;
         discard_ff  <= discard_in;
         s1_valid_ff <= s1_valid_in;
         mod_ff      <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.advance) begin
         s1_ff <= s1_in;
      end
   end

   // While the stage is held, its own entry is read again so that the data stays aligned.
   assign rd_addr  = flow.accept ? ADDR_W'(idx) : ADDR_W'(s1_ff.idx);
   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

`default_nettype wire

[hdl/pru_recon.sv]
`default_nettype none

module pru_recon #(
   parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pru_pkg::flow_type           flow,
   input  wire logic                        s1_valid,
   input  wire pru_pkg::stage_type          s1,
   input  wire logic [pru_pkg::BYTE_W-1:0]  rd_data,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output pru_pkg::rsp_type                 rsp_data,
   output logic                             wr_en,
   output logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] wr_addr,
   output logic [pru_pkg::BYTE_W-1:0]       wr_data
);

   localparam int ADDR_W = MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int HIST_W = MAX_PIXEL_BYTES > 1 ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic [pru_pkg::BYTE_W-1:0] left_ff  [MAX_PIXEL_BYTES];
   logic [pru_pkg::BYTE_W-1:0] upper_ff [MAX_PIXEL_BYTES];
   logic                       rsp_valid_ff;
   pru_pkg::rsp_type           rsp_data_ff;

   logic [HIST_W-1:0]          slot;
   logic [pru_pkg::BYTE_W-1:0] a, b, c, paeth, pred, val;
   logic [8:0]                 sum_ab;
   logic signed [9:0]          d_bc, d_ac;
   logic signed [10:0]         d_p;
   logic [9:0]                 pa, pb, pc;
   logic                       fire, pixel;

   always_comb begin
      slot   = HIST_W'(s1.slot);
      a      = s1.use_left ? left_ff[slot] : '0;
      b      = s1.use_upper ? rd_data : '0;
      c      = (s1.use_left && s1.use_upper) ? upper_ff[slot] : '0;
      sum_ab = {1'b0, a} + {1'b0, b};
      // Distances from a + b - c to a, b and c.
      d_bc = $signed({2'b0, b}) - $signed({2'b0, c});
      d_ac = $signed({2'b0, a}) - $signed({2'b0, c});
      d_p  = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({2'b0, c, 1'b0});
      pa   = d_bc[9] ? 10'(-d_bc) : 10'(d_bc);
      pb   = d_ac[9] ? 10'(-d_ac) : 10'(d_ac);
      pc   = d_p[10] ? 10'(-d_p) : 10'(d_p);
      if (pa <= pb && pa <= pc) begin
         paeth = a;
      end else if (pb <= pc) begin
         paeth = b;
      end else begin
         paeth = c;
      end
      case (s1.filter)
         pru_pkg::FILT_SUB: begin
            pred = a;
         end
         pru_pkg::FILT_UP: begin
            pred = b;
         end
         pru_pkg::FILT_AVG: begin
            pred = sum_ab[8:1];
         end
         pru_pkg::FILT_PAETH: begin
            pred = paeth;
         end
         default: begin
            pred = '0;
         end
      endcase
      val   = s1.data + pred;
      fire  = s1_valid && flow.advance;
      pixel = fire && (s1.kind == pru_pkg::ITEM_PIXEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]  <= '0;
            upper_ff[i] <= '0;
         end
      end else if (pixel) begin
         left_ff[slot]  <= val;
         upper_ff[slot] <= b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && s1.kind != pru_pkg::ITEM_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && s1.kind != pru_pkg::ITEM_NONE) begin
         if (s1.kind == pru_pkg::ITEM_BAD) begin
            rsp_data_ff.pixel_byte <= '0;
            rsp_data_ff.row_end    <= 1'b0;
            rsp_data_ff.bad_filter <= 1'b1;
         end else begin
            rsp_data_ff.pixel_byte <= val;
            rsp_data_ff.row_end    <= s1.last;
            rsp_data_ff.bad_filter <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign wr_en     = pixel;
   assign wr_addr   = ADDR_W'(s1.idx);
   assign wr_data   = val;

endmodule

`default_nettype wire

[hdl/png_row_unfilter.sv]
`default_nettype none

// PNG scanline unfilter taking one stream byte per beat: a filter type byte opens each row and
// the configured number of data bytes follows, each rebuilt with the none, sub, up, average or
// Paeth predictor. A byte is accepted every clock cycle while results are taken. An accepted
// byte is registered into the working stage and its result beat is registered from there; the
// previous-row memory has a registered read, issued in the cycle a byte is accepted, and is
// written back when the byte leaves the working stage.
// Filter type bytes give no result unless the type is 5 or more, when one bad_filter beat is
// sent and the row's data bytes are dropped. The previous-row memory has no clearing pass and
// holds MAX_ROW_BYTES bytes; image_start on a row's filter byte makes the upper neighbours
// read as zero. The user writes registers via csr only with no beat in flight; not enforced.
module png_row_unfilter #(
   parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire pru_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output pru_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pru_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W = MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1;

   pru_pkg::cfg_type           cfg_ff;
   pru_pkg::flow_type          flow;
   pru_pkg::stage_type         s1;
   logic                       s1_valid;
   logic [ADDR_W-1:0]          rd_addr, wr_addr;
   logic [pru_pkg::BYTE_W-1:0] rd_data, wr_data;
   logic                       wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= pru_pkg::BPP_W'(1);
         cfg_ff.row_length      <= pru_pkg::POS_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            pru_pkg::CSR_BYTES_PER_PIXEL: begin
               cfg_ff.bytes_per_pixel <= csr_wdata[pru_pkg::BPP_W-1:0];
            end
            pru_pkg::CSR_ROW_BYTES: begin
               cfg_ff.row_length <= csr_wdata[pru_pkg::POS_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign csr_ready    = 1'b1;
   assign flow.advance = !s1_valid || !rsp_valid || rsp_ready;
   assign flow.accept  = req_valid && flow.advance;
   assign req_ready    = flow.advance;

   pru_ctrl #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .flow     (flow),
      .cfg      (cfg_ff),
      .req      (req_data),
      .s1_valid (s1_valid),
      .s1       (s1),
      .rd_addr  (rd_addr)
   );

   pru_prior_mem #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_prior_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pru_recon #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .s1_valid  (s1_valid),
      .s1        (s1),
      .rd_data   (rd_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid && !flow.advance |=> s1_valid && $stable(s1))
      else $error("working stage changed while stalled");

   a_write_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid && !rsp_data.bad_filter)
      else $error("previous-row write without a pixel beat");

   a_row_end_follows: assert property (@(posedge clock) disable iff (reset)
      wr_en && s1.last |=> rsp_data.row_end)
      else $error("last byte of a row sent without row_end");

endmodule

`default_nettype wire

[bench/tb_png_row_unfilter.sv]
`timescale 1ns / 1ps

module tb_png_row_unfilter;

   localparam int ROW_LIMIT     = pru_pkg::MAX_ROW_BYTES_DEF;
   localparam int PIXEL_LIMIT   = pru_pkg::MAX_PIXEL_BYTES_DEF;
   localparam int AVG_DIVISOR   = 2;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_BEATS  = 560;
   localparam int LONG_ROW      = 100;
   localparam int PRINT_LIMIT   = 50;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC
   } rx_pattern_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   pru_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   pru_pkg::rsp_type               rsp_data;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [pru_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pru_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Model of the unfilter state, advanced at each accepted request beat.
   logic [7:0]      prior_row_mem [ROW_LIMIT];
   logic [7:0]      left_bytes [PIXEL_LIMIT];
   logic [7:0]      upper_left_bytes [PIXEL_LIMIT];
   int              row_pos;
   logic [2:0]      cur_filter;
   bit              no_upper_row;
   bit              dropping_row;
   logic [3:0]      cfg_bpp;
   logic [12:0]     cfg_row_len;
   int              written_hi;

   pru_pkg::rsp_type expected_bytes [$];

   int              mismatches;
   int              checked;
   int              beats_used;
   int              rows_done;
   int              bad_rows;
   int              filter_rows [5];
   int              burst_left;
   int              idle_max;
   rx_pattern_type  stall_mode;
   int              stall_tick;
   int              cycle_count;

   png_row_unfilter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      stall_tick++;
      case (stall_mode)
         RX_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_ready <= ((stall_tick % 13) < 7);
         end
      endcase
   end

   function automatic int eff_bpp();
      int v;
      v = cfg_bpp;
      if (v == 0) v = 1;
      if (v > PIXEL_LIMIT) v = PIXEL_LIMIT;
      return v;
   endfunction

   function automatic int eff_row_len();
      int v;
      v = cfg_row_len;
      if (v == 0) v = 1;
      if (v > ROW_LIMIT) v = ROW_LIMIT;
      return v;
   endfunction

   function automatic int paeth_pick(input int a, input int b, input int c);
      int p;
      int pa;
      int pb;
      int pc;
      p  = a + b - c;
      pa = (p > a) ? p - a : a - p;
      pb = (p > b) ? p - b : b - p;
      pc = (p > c) ? p - c : c - p;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   task automatic unfilter_byte(input pru_pkg::req_type item);
      int               rlen;
      int               bpp;
      int               idx;
      int               slot;
      int               a;
      int               b;
      int               c;
      int               pred;
      logic [7:0]       val;
      bit               last;
      pru_pkg::rsp_type res;
      rlen = eff_row_len();
      bpp  = eff_bpp();
      if (row_pos == 0) begin
         if (item.image_start) no_upper_row = 1'b1;
         row_pos = 1;
         if (item.data_byte >= pru_pkg::FILTER_KINDS) begin
            cur_filter   = pru_pkg::FILT_NONE;
            dropping_row = 1'b1;
            res          = '0;
            res.bad_filter = 1'b1;
            expected_bytes.push_back(res);
            bad_rows++;
         end else begin
            cur_filter   = item.data_byte[2:0];
            dropping_row = 1'b0;
            filter_rows[cur_filter]++;
         end
         return;
      end
      idx  = row_pos - 1;
      last = (row_pos >= rlen);
      row_pos = last ? 0 : row_pos + 1;
      if (dropping_row) begin
         if (last) dropping_row = 1'b0;
         return;
      end
      if (idx >= ROW_LIMIT) idx = ROW_LIMIT - 1;
      slot = idx % bpp;
      a = (idx >= bpp) ? int'(left_bytes[slot]) : 0;
      b = no_upper_row ? 0 : int'(prior_row_mem[idx]);
      c = (!no_upper_row && idx >= bpp) ? int'(upper_left_bytes[slot]) : 0;
      case (cur_filter)
         pru_pkg::FILT_SUB:   pred = a;
         pru_pkg::FILT_UP:    pred = b;
         pru_pkg::FILT_AVG:   pred = (a + b) / AVG_DIVISOR;
         pru_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
         default:             pred = 0;
      endcase
      val = 8'(int'(item.data_byte) + pred);
      left_bytes[slot]       = val;
      upper_left_bytes[slot] = 8'(b);
      prior_row_mem[idx]     = val;
      if (idx + 1 > written_hi) written_hi = idx + 1;
      if (last) begin
         no_upper_row = 1'b0;
         rows_done++;
      end
      res.pixel_byte = val;
      res.row_end    = last;
      res.bad_filter = 1'b0;
      expected_bytes.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("Mismatch at result beat %0d: %s, got %0h, expected %0h",
                  checked, what, got, want);
   endtask

   always @(posedge clock) begin
      pru_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("result beat with nothing expected", int'(rsp_data), 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.pixel_byte !== want.pixel_byte)
               report_mismatch("pixel_byte", int'(rsp_data.pixel_byte),
                               int'(want.pixel_byte));
            if (rsp_data.row_end !== want.row_end)
               report_mismatch("row_end", int'(rsp_data.row_end), int'(want.row_end));
            if (rsp_data.bad_filter !== want.bad_filter)
               report_mismatch("bad_filter", int'(rsp_data.bad_filter),
                               int'(want.bad_filter));
         end
         checked++;
      end
   end

   task automatic drive_beat(input logic [7:0] value, input logic img);
      pru_pkg::req_type item;
      int               gap;
      item.data_byte   = value;
      item.image_start = img;
      if (burst_left == 0) begin
         gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      beats_used++;
      unfilter_byte(item);
      @(negedge clock);
   endtask

   task automatic finish_row(input int fill);
      while (row_pos != 0)
         drive_beat((fill < 0) ? 8'($urandom) : 8'(fill), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_row(input logic [7:0] filt, input logic img, input int fill);
      // A row that would read the stored row beyond what has been written opens a new image.
      if (!img && !no_upper_row && eff_row_len() > written_hi) img = 1'b1;
      drive_beat(filt, img);
      finish_row(fill);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_bytes.size() != 0) begin
         report_mismatch("result beats never arrived", expected_bytes.size(), 0);
         expected_bytes.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [pru_pkg::CSR_IDX_W-1:0] idx, input int value);
      drain();
      csr_index <= idx;
      csr_wdata <= pru_pkg::CSR_DATA_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == pru_pkg::CSR_BYTES_PER_PIXEL) cfg_bpp = 4'(value);
      else cfg_row_len = 13'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_filter_types();
      idle_max   = 0;
      stall_mode = RX_ALWAYS;
      write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, 2);
      write_reg(pru_pkg::CSR_ROW_BYTES, 4);
      send_row(8'(pru_pkg::FILT_NONE), 1'b1, 0);
      send_row(8'(pru_pkg::FILT_SUB), 1'b0, 255);
      send_row(8'(pru_pkg::FILT_UP), 1'b0, -1);
      send_row(8'(pru_pkg::FILT_AVG), 1'b0, 255);
      send_row(8'(pru_pkg::FILT_PAETH), 1'b0, -1);
   endtask

   task automatic test_bad_filter();
      idle_max   = 3;
      stall_mode = RX_RANDOM;
      send_row(pru_pkg::FILTER_KINDS, 1'b0, -1);
      send_row(8'(pru_pkg::FILT_PAETH), 1'b0, -1);
      send_row(8'hFF, 1'b1, -1);
      send_row(8'(pru_pkg::FILT_UP), 1'b0, -1);
      send_row(8'(pru_pkg::FILT_PAETH), 1'b0, -1);
   endtask

   task automatic test_register_extremes();
      idle_max   = 2;
      stall_mode = RX_PERIODIC;
      write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, 0);
      write_reg(pru_pkg::CSR_ROW_BYTES, 0);
      send_row(8'(pru_pkg::FILT_SUB), 1'b1, -1);
      send_row(8'(pru_pkg::FILT_PAETH), 1'b0, -1);
      write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, 15);
      write_reg(pru_pkg::CSR_ROW_BYTES, 12);
      send_row(8'(pru_pkg::FILT_PAETH), 1'b0, -1);
      send_row(8'(pru_pkg::FILT_AVG), 1'b0, -1);
      write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, PIXEL_LIMIT);
      send_row(8'(pru_pkg::FILT_SUB), 1'b0, -1);
   endtask

   task automatic test_mid_row_change();
      int i;
      idle_max   = 0;
      stall_mode = RX_ALWAYS;
      write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, 1);
      write_reg(pru_pkg::CSR_ROW_BYTES, 2);
      drive_beat(8'(pru_pkg::FILT_AVG), 1'b1);
      drive_beat(8'($urandom), 1'b0);
      write_reg(pru_pkg::CSR_ROW_BYTES, 5);
      finish_row(-1);
      write_reg(pru_pkg::CSR_ROW_BYTES, 6);
      drive_beat(8'(pru_pkg::FILT_PAETH), 1'b1);
      for (i = 0; i < 3; i++) drive_beat(8'($urandom), 1'b0);
      write_reg(pru_pkg::CSR_ROW_BYTES, 2);
      finish_row(-1);
      send_row(8'(pru_pkg::FILT_UP), 1'b0, -1);
   endtask

   task automatic test_long_rows();
      idle_max   = 1;
      stall_mode = RX_RANDOM;
      write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, 3);
      write_reg(pru_pkg::CSR_ROW_BYTES, LONG_ROW);
      send_row(8'(pru_pkg::FILT_SUB), 1'b1, -1);
      send_row(8'(pru_pkg::FILT_PAETH), 1'b0, -1);
   endtask

   task automatic test_random_stream();
      int          start_beats;
      int          phase_end;
      int          rb;
      logic [7:0]  filt;
      logic        img;
      start_beats = beats_used;
      while (beats_used - start_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 4) == 0)
            write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, $urandom_range(0, 15));
         else write_reg(pru_pkg::CSR_BYTES_PER_PIXEL, $urandom_range(1, PIXEL_LIMIT));
         case ($urandom_range(0, 9))
            0:       rb = 0;
            1:       rb = $urandom_range(25, 120);
            default: rb = $urandom_range(1, 24);
         endcase
         write_reg(pru_pkg::CSR_ROW_BYTES, rb);
         case ($urandom_range(0, 2))
            0:       idle_max = 0;
            1:       idle_max = 2;
            default: idle_max = 6;
         endcase
         stall_mode = rx_pattern_type'($urandom_range(0, 2));
         phase_end  = beats_used + $urandom_range(40, 150);
         while (beats_used < phase_end) begin
            if ($urandom_range(0, 19) < 17) filt = 8'($urandom_range(0, 4));
            else filt = 8'($urandom_range(5, 255));
            img = ($urandom_range(0, 6) == 0);
            send_row(filt, img, -1);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      row_pos       = 0;
      cur_filter    = pru_pkg::FILT_NONE;
      no_upper_row  = 1'b1;
      dropping_row  = 1'b0;
      cfg_bpp       = 4'd1;
      cfg_row_len   = 13'd1;
      written_hi    = 0;
      mismatches    = 0;
      checked       = 0;
      beats_used    = 0;
      rows_done     = 0;
      bad_rows      = 0;
      filter_rows   = '{default: 0};
      burst_left    = 0;
      idle_max      = 0;
      stall_mode    = RX_ALWAYS;
      stall_tick    = 0;
      cycle_count   = 0;
      for (int i = 0; i < PIXEL_LIMIT; i++) begin
         left_bytes[i]       = 8'd0;
         upper_left_bytes[i] = 8'd0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_filter_types();
      test_bad_filter();
      test_register_extremes();
      test_mid_row_change();
      test_long_rows();
      test_random_stream();
      drain();

      $display("Checked %0d result beats from %0d beats: %0d rows rebuilt, %0d bad filter rows.",
               checked, beats_used, rows_done, bad_rows);
      $display("Rows by filter type none/sub/up/average/Paeth: %0d/%0d/%0d/%0d/%0d.",
               filter_rows[0], filter_rows[1], filter_rows[2], filter_rows[3],
               filter_rows[4]);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/pru_pkg.sv
hdl/pru_prior_mem.sv
hdl/pru_ctrl.sv
hdl/pru_recon.sv
hdl/png_row_unfilter.sv
bench/tb_png_row_unfilter.sv
